@@ hw/rtl/gdbd_pkg.sv @@
package gdbd_pkg;

  localparam int YearW     = 12;
  localparam int MonthW    = 4;
  localparam int DayW      = 5;
  localparam int DiffW     = 18;
  localparam int CountW    = 22;
  localparam int Q4W       = YearW - 2;
  localparam int ProdW     = 16;
  localparam int CentW     = 6;
  localparam int DayPartW  = 9;

  localparam logic [YearW-1:0] BaseYearReset = 12'd1980;
  localparam logic [ProdW-1:0] RecipQ25      = 16'd41;
  localparam logic [Q4W-1:0]   Century4      = 10'd25;
  localparam logic [CountW-1:0] DaysPerYear  = 22'd365;

  typedef struct packed {
    logic [YearW-1:0]  first_year;
    logic [MonthW-1:0] first_month;
    logic [DayW-1:0]   first_day;
    logic [YearW-1:0]  second_year;
    logic [MonthW-1:0] second_month;
    logic [DayW-1:0]   second_day;
  } in_t;

  typedef struct packed {
    logic signed [DiffW-1:0] days_between;
    logic                    out_of_range;
  } out_t;

  typedef struct packed {
    logic en1;
    logic en2;
  } lane_ctrl_t;

  // Days before the first of the month; out-of-range months clamp to January or December.
  function automatic logic [DayPartW-1:0] month_offset(input logic [MonthW-1:0] m);
    logic [DayPartW-1:0] r;
    unique case (m)
      4'd0, 4'd1: r = 9'd0;
      4'd2:       r = 9'd31;
      4'd3:       r = 9'd59;
      4'd4:       r = 9'd90;
      4'd5:       r = 9'd120;
      4'd6:       r = 9'd151;
      4'd7:       r = 9'd181;
      4'd8:       r = 9'd212;
      4'd9:       r = 9'd243;
      4'd10:      r = 9'd273;
      4'd11:      r = 9'd304;
      default:    r = 9'd334;
    endcase
    return r;
  endfunction

endpackage

@@ hw/rtl/gregorian_days_between_dates.sv @@
// Signed day count between two Gregorian dates.
// The input channel carries one pair of dates per transaction on in_data_i,
// qualified by in_valid_i and held off by in_stall_o. The output channel
// returns one transaction per input on out_data_o with out_valid_o, and the
// receiver holds it with out_stall_i.
// Each date goes through its own two-stage lane that forms an absolute day
// number; a merge stage subtracts the two numbers, saturates to 18 bits and
// registers the result. The result passes through both lane registers and the
// merge output register before it shows on out_valid_o. One transaction is
// accepted every cycle while the receiver does not stall the output.
// A year below the base year gives out_of_range and a zero difference.
// The user must write the base year through cfg_we_i and cfg_data_i while
// idle; the block does not enforce this. Reset empties the pipeline and sets
// the base year to 1980. When the receiver stalls, results back up through
// the three stages and in_stall_o rises once every stage holds a transaction.
module gregorian_days_between_dates import gdbd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_t              in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_t             out_data_o,
  input  logic             cfg_we_i,
  input  logic [YearW-1:0] cfg_data_i
);

  logic [YearW-1:0]  base_year_q;
  logic              v1_q, v2_q, v3_q;
  logic              oor1_q, oor2_q;
  logic              ready1, ready2, ready3;
  logic              oor_in;
  lane_ctrl_t        lane_ctrl;
  logic              merge_en;
  logic [CountW-1:0] count_first, count_second;

  assign ready3 = !v3_q || !out_stall_i;
  assign ready2 = !v2_q || ready3;
  assign ready1 = !v1_q || ready2;

  assign lane_ctrl.en1 = ready1 && in_valid_i;
  assign lane_ctrl.en2 = ready2 && v1_q;
  assign merge_en      = ready3 && v2_q;

  assign oor_in = (in_data_i.first_year < base_year_q) ||
                  (in_data_i.second_year < base_year_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_year_q <= BaseYearReset;
    end else if (cfg_we_i) begin
      base_year_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (ready1) begin
        v1_q <= in_valid_i;
      end
      if (ready2) begin
        v2_q <= v1_q;
      end
      if (ready3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (lane_ctrl.en1) begin
      oor1_q <= oor_in;
    end
    if (lane_ctrl.en2) begin
      oor2_q <= oor1_q;
    end
  end

  gdbd_lane u_lane_first (
    .clk_i   (clk_i),
    .ctrl_i  (lane_ctrl),
    .year_i  (in_data_i.first_year),
    .month_i (in_data_i.first_month),
    .day_i   (in_data_i.first_day),
    .count_o (count_first)
  );

  gdbd_lane u_lane_second (
    .clk_i   (clk_i),
    .ctrl_i  (lane_ctrl),
    .year_i  (in_data_i.second_year),
    .month_i (in_data_i.second_month),
    .day_i   (in_data_i.second_day),
    .count_o (count_second)
  );

  gdbd_merge u_merge (
    .clk_i          (clk_i),
    .en_i           (merge_en),
    .count_first_i  (count_first),
    .count_second_i (count_second),
    .oor_i          (oor2_q),
    .data_o         (out_data_o)
  );

  assign in_stall_o  = !ready1;
  assign out_valid_o = v3_q;

  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> v1_q)
    else $error("accepted transaction did not enter the first stage");

  a_no_stall_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v1_q |-> !in_stall_o)
    else $error("input stalled while the first stage is empty");

  a_out_leaves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i && !merge_en) |=> out_valid_o)
    else $error("stalled result was dropped");

  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.out_of_range) |-> (out_data_o.days_between == '0))
    else $error("out-of-range result carries a nonzero difference");

endmodule

@@ hw/rtl/gdbd_lane.sv @@
module gdbd_lane import gdbd_pkg::*; (
  input  logic              clk_i,
  input  lane_ctrl_t        ctrl_i,
  input  logic [YearW-1:0]  year_i,
  input  logic [MonthW-1:0] month_i,
  input  logic [DayW-1:0]   day_i,
  output logic [CountW-1:0] count_o
);

  logic [YearW-1:0]    prev_year;
  logic [Q4W-1:0]      prev_q4;
  logic [ProdW-1:0]    prev_prod;
  logic [CentW-1:0]    prev_q100;
  logic [Q4W-1:0]      year_q4;
  logic [ProdW-1:0]    year_prod;
  logic [CentW-1:0]    year_q100;
  logic [Q4W-1:0]      year_c25;
  logic                div4;
  logic                div100;
  logic                leap;
  logic                late_month;

  logic [CountW-1:0]   y365_d, y365_q;
  logic [Q4W-1:0]      prev_q4_q;
  logic [CentW-1:0]    prev_q100_q;
  logic                nonzero_d, nonzero_q;
  logic [DayPartW-1:0] day_part_d, day_part_q;
  logic [Q4W-1:0]      leaps;
  logic [CountW-1:0]   count_d, count_q;

  // Division by 100 is a shift by two followed by a reciprocal multiply for 25.
  always_comb begin
    prev_year  = year_i - YearW'(1);
    prev_q4    = prev_year[YearW-1:2];
    prev_prod  = ProdW'(prev_q4) * RecipQ25;
    prev_q100  = prev_prod[ProdW-1:ProdW-CentW];
    year_q4    = year_i[YearW-1:2];
    year_prod  = ProdW'(year_q4) * RecipQ25;
    year_q100  = year_prod[ProdW-1:ProdW-CentW];
    year_c25   = Q4W'(year_q100) * Century4;
    div4       = (year_i[1:0] == 2'd0);
    div100     = div4 && (year_q4 == year_c25);
    leap       = (div4 && !div100) || (div100 && (year_q100[1:0] == 2'd0));
    late_month = (month_i > MonthW'(2));
    y365_d     = CountW'(year_i) * DaysPerYear;
    nonzero_d  = (year_i != '0);
    day_part_d = month_offset(month_i) + DayPartW'(leap && late_month) + DayPartW'(day_i);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en1) begin
      y365_q      <= y365_d;
      prev_q4_q   <= prev_q4;
      prev_q100_q <= prev_q100;
      nonzero_q   <= nonzero_d;
      day_part_q  <= day_part_d;
    end
  end

  always_comb begin
    if (nonzero_q) begin
      leaps = prev_q4_q - Q4W'(prev_q100_q) + Q4W'(prev_q100_q[CentW-1:2]) + Q4W'(1);
    end else begin
      leaps = '0;
    end
    count_d = y365_q + CountW'(leaps) + CountW'(day_part_q);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en2) begin
      count_q <= count_d;
    end
  end

  assign count_o = count_q;

endmodule

@@ hw/rtl/gdbd_merge.sv @@
module gdbd_merge import gdbd_pkg::*; (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [CountW-1:0] count_first_i,
  input  logic [CountW-1:0] count_second_i,
  input  logic              oor_i,
  output out_t              data_o
);

  localparam int SumW = CountW + 1;
  localparam logic signed [SumW-1:0] DiffMax = SumW'((1 << (DiffW - 1)) - 1);
  localparam logic signed [SumW-1:0] DiffMin = -SumW'(1 << (DiffW - 1));

  logic signed [SumW-1:0] diff;
  out_t                   data_d, data_q;

  always_comb begin
    diff = $signed({1'b0, count_second_i}) - $signed({1'b0, count_first_i});
    data_d.out_of_range = oor_i;
    priority if (oor_i) begin
      data_d.days_between = '0;
    end else if (diff > DiffMax) begin
      data_d.days_between = DiffMax[DiffW-1:0];
    end else if (diff < DiffMin) begin
      data_d.days_between = DiffMin[DiffW-1:0];
    end else begin
      data_d.days_between = diff[DiffW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign data_o = data_q;

endmodule
